FILE: sv/tksel_pkg.sv
// shared types and constants for the top-k score selector
`default_nettype none

package tksel_pkg;

    // default number of held entries
    localparam int KEEP_COUNT_DEF = 16;

    // command codes
    localparam logic OP_OFFER = 1'b0;
    localparam logic OP_DRAIN = 1'b1;

    // one command transfer
    typedef struct packed {
        logic        opcode;
        logic [31:0] doc_id;
        logic [31:0] score;
    } cmd_t;

    // one result transfer
    typedef struct packed {
        logic [31:0] out_doc_id;
        logic [31:0] out_score;
        logic        entry_valid;
        logic        last;
    } res_t;

    // contents of one cell
    typedef struct packed {
        logic        valid;
        logic [31:0] score;
        logic [31:0] doc_id;
    } entry_t;

    // broadcast control from the top level to every cell
    typedef struct packed {
        logic        offer;
        logic        drain;
        logic [31:0] score;
        logic [31:0] doc_id;
    } cell_ctrl_t;

endpackage

`default_nettype wire

FILE: sv/top_k_score_selector_core.sv
// top level of the top-k score selector: chain of sorted cells and drain control
//
//  channel   | signals              | direction | transfer when
//  ----------+----------------------+-----------+----------------------------
//  command   | start, busy, cmd     | in        | start high and busy low
//  result    | strobe, res          | out       | strobe high (one cycle each)
//
// on an offer every cell compares against the offer at once and
// the chain shifts right by one from the insertion point, so busy stays low.
// a drain holds busy high after its transfer until the last result, one result per
// cycle shifted out of the head cell; an empty store gives one empty result.
// reset clears all valid flags and the drain flag; results cannot be stalled.
`default_nettype none

module top_k_score_selector_core #(
    parameter int KEEP_COUNT = tksel_pkg::KEEP_COUNT_DEF
) (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            start,
    output logic                 busy,
    input  wire tksel_pkg::cmd_t cmd,
    output logic                 strobe,
    output tksel_pkg::res_t      res
);
    import tksel_pkg::*;

    logic       drain_reg;
    logic       drain_next;
    logic       accept;
    cell_ctrl_t ctrl;
    entry_t     ents  [0:KEEP_COUNT];
    logic       stays [0:KEEP_COUNT];

    assign accept = start && !drain_reg;
    assign busy   = drain_reg;
    assign strobe = drain_reg;

    // broadcast control
    always_comb
    begin
        ctrl.offer  = accept && (cmd.opcode == OP_OFFER);
        ctrl.drain  = drain_reg;
        ctrl.score  = cmd.score;
        ctrl.doc_id = cmd.doc_id;
    end

    // chain ends: head always inserts, tail pad is empty
    assign stays[0]        = 1'b1;
    assign ents[KEEP_COUNT] = '0;

    // the row of cells
    for (genvar i = 0; i < KEEP_COUNT; i++)
    begin : g_cell
        entry_t left_ent;
        if (i == 0)
        begin : g_head
            assign left_ent = '0;
        end
        else
        begin : g_body
            assign left_ent = ents[i-1];
        end
        tksel_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .ctrl      (ctrl),
            .left      (left_ent),
            .left_stay (stays[i]),
            .right     (ents[i+1]),
            .ent       (ents[i]),
            .stay      (stays[i+1])
        );
    end

    // drain flag: set on a drain transfer, cleared after the last result
    always_comb
    begin
        drain_next = drain_reg;
        if (accept && (cmd.opcode == OP_DRAIN))
        begin
            drain_next = 1'b1;
        end
        else if (drain_reg && !ents[1].valid)
        begin
            drain_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            drain_reg <= 1'b0;
        end
        else
        begin
            drain_reg <= drain_next;
        end
    end

    // result from the head cell, zeroed when empty
    always_comb
    begin
        res.out_doc_id  = ents[0].valid ? ents[0].doc_id : 32'd0;
        res.out_score   = ents[0].valid ? ents[0].score : 32'd0;
        res.entry_valid = ents[0].valid;
        res.last        = !ents[1].valid;
    end

    // a drain transfer is followed by a result
    a_drain_strobe: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (cmd.opcode == OP_DRAIN)) |=> strobe)
        else $error("drain not followed by result");

    // the last result ends the drain
    a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (strobe && res.last) |=> !busy)
        else $error("busy after last result");

    // an empty result is always the last one
    a_empty_last: assert property (@(posedge clk) disable iff (!rst_n)
        (strobe && !res.entry_valid) |-> res.last)
        else $error("empty result not marked last");

    // head pair stays ordered and packed
    a_head_sorted: assert property (@(posedge clk) disable iff (!rst_n)
        ents[1].valid |-> (ents[0].valid && (ents[0].score >= ents[1].score)))
        else $error("chain head out of order");

    // a full chain drops an offer only when it ranks at or below the tail
    a_drop_rule: assert property (@(posedge clk) disable iff (!rst_n)
        (ctrl.offer && stays[KEEP_COUNT]) |->
            (ents[KEEP_COUNT-1].valid && (ents[KEEP_COUNT-1].score >= cmd.score)))
        else $error("offer dropped wrongly");

endmodule

`default_nettype wire

FILE: sv/tksel_cell.sv
// one cell of the sorted chain: holds an entry, inserts or shifts
`default_nettype none

module tksel_cell (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire tksel_pkg::cell_ctrl_t ctrl,
    input  wire tksel_pkg::entry_t   left,
    input  wire logic                left_stay,
    input  wire tksel_pkg::entry_t   right,
    output tksel_pkg::entry_t        ent,
    output logic                     stay
);
    import tksel_pkg::*;

    logic        valid_reg;
    logic        valid_next;
    logic [31:0] score_reg;
    logic [31:0] score_next;
    logic [31:0] doc_id_reg;
    logic [31:0] doc_id_next;

    // entry keeps its place when it ranks at or above the offer
    assign stay = valid_reg && (score_reg >= ctrl.score);

    // next contents: insert, shift right on offer, shift left on drain
    always_comb
    begin
        valid_next  = valid_reg;
        score_next  = score_reg;
        doc_id_next = doc_id_reg;
        if (ctrl.drain)
        begin
            valid_next  = right.valid;
            score_next  = right.score;
            doc_id_next = right.doc_id;
        end
        else if (ctrl.offer && !stay)
        begin
            if (left_stay)
            begin
                valid_next  = 1'b1;
                score_next  = ctrl.score;
                doc_id_next = ctrl.doc_id;
            end
            else
            begin
                valid_next  = left.valid;
                score_next  = left.score;
                doc_id_next = left.doc_id;
            end
        end
    end

    // valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        score_reg  <= score_next;
        doc_id_reg <= doc_id_next;
    end

    assign ent = '{valid: valid_reg, score: score_reg, doc_id: doc_id_reg};

endmodule

`default_nettype wire

FILE: sim/tksel_rank_checker.sv
// checker for the top-k score selector: predicts each drain's ranking and compares results
`timescale 1ns / 100ps

module tksel_rank_checker #(
    parameter int KEEP = tksel_pkg::KEEP_COUNT_DEF
) (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            start,
    input  wire logic            busy,
    input  wire tksel_pkg::cmd_t cmd,
    input  wire logic            strobe,
    input  wire tksel_pkg::res_t res,
    output int                   mismatches,
    output int                   outstanding
);

    // predicted store, ranked by score descending then by arrival
    logic [31:0] held_score [KEEP];
    logic [31:0] held_id    [KEEP];
    int          held_num;

    // ranked entries still due on the result channel
    tksel_pkg::res_t due_q [$];

    initial
    begin
        mismatches  = 0;
        outstanding = 0;
    end

    // one line per mismatch
    task automatic note_mismatch(input string msg);
        begin
            $display("mismatch at %0t: %s", $time, msg);
            mismatches++;
        end
    endtask

    // append one expected result behind those already due
    task automatic queue_due(input tksel_pkg::res_t r);
        begin
            due_q.insert(due_q.size(), r);
        end
    endtask

    // offer: keep while not full, else replace the lowest if strictly better
    task automatic admit_offer(input logic [31:0] id, input logic [31:0] sc);
        int pos;
        begin
            if (held_num == KEEP)
            begin
                // at or below the lowest held score: dropped
                if (sc <= held_score[KEEP-1])
                    return;
                // the latest arrival among the lowest scores is pushed out
                held_num = KEEP - 1;
            end
            pos = 0;
            // equal scores stay ahead of the newcomer
            while (pos < held_num && held_score[pos] >= sc)
                pos++;
            for (int i = held_num; i > pos; i--)
            begin
                held_score[i] = held_score[i-1];
                held_id[i]    = held_id[i-1];
            end
            held_score[pos] = sc;
            held_id[pos]    = id;
            held_num++;
        end
    endtask

    // drain: every held entry in rank order, or one empty marker
    task automatic rank_drain();
        tksel_pkg::res_t r;
        begin
            if (held_num == 0)
            begin
                r      = '0;
                r.last = 1'b1;
                queue_due(r);
            end
            else
            begin
                for (int i = 0; i < held_num; i++)
                begin
                    r.out_doc_id  = held_id[i];
                    r.out_score   = held_score[i];
                    r.entry_valid = 1'b1;
                    r.last        = (i == held_num - 1);
                    queue_due(r);
                end
            end
            held_num = 0;
        end
    endtask

    // compare one result transfer with the oldest due entry
    task automatic check_result(input tksel_pkg::res_t got);
        tksel_pkg::res_t want;
        begin
            if (due_q.size() == 0)
            begin
                note_mismatch($sformatf("result id %h score %h with nothing due",
                                        got.out_doc_id, got.out_score));
                return;
            end
            want = due_q.pop_front();
            if (got.out_doc_id !== want.out_doc_id)
                note_mismatch($sformatf("out_doc_id %h, want %h",
                                        got.out_doc_id, want.out_doc_id));
            if (got.out_score !== want.out_score)
                note_mismatch($sformatf("out_score %h, want %h (id %h)",
                                        got.out_score, want.out_score, want.out_doc_id));
            if (got.entry_valid !== want.entry_valid)
                note_mismatch($sformatf("entry_valid %b, want %b",
                                        got.entry_valid, want.entry_valid));
            if (got.last !== want.last)
                note_mismatch($sformatf("last %b, want %b (id %h)",
                                        got.last, want.last, want.out_doc_id));
        end
    endtask

    // sample both channels at each rising edge
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_num = 0;
            due_q.delete();
            outstanding <= 0;
        end
        else
        begin
            if (strobe)
                check_result(res);
            if (start && !busy)
            begin
                if (cmd.opcode == tksel_pkg::OP_OFFER)
                    admit_offer(cmd.doc_id, cmd.score);
                else
                    rank_drain();
            end
            outstanding <= due_q.size();
        end
    end

endmodule

FILE: sim/tb_top_k_score_selector_core.sv
// testbench top for the top-k score selector: stimulus, clock, reset and verdict
`timescale 1ns / 100ps

module tb_top_k_score_selector_core;

    localparam int KEEP      = tksel_pkg::KEEP_COUNT_DEF;
    localparam int ITEMS     = 280;
    localparam int TAIL      = KEEP + 8;
    localparam int MAX_CYCLE = 200000;

    logic            clk = 1'b0;
    logic            rst_n;
    logic            start;
    logic            busy;
    tksel_pkg::cmd_t cmd_in;
    logic            strobe;
    tksel_pkg::res_t res_out;
    int              mismatches;
    int              outstanding;

    int sent       = 0;
    int burst_left = 0;
    int cycles     = 0;

    // clock
    always #6 clk = ~clk;

    top_k_score_selector_core #(
        .KEEP_COUNT(KEEP)
    ) dut (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .cmd   (cmd_in),
        .strobe(strobe),
        .res   (res_out)
    );

    tksel_rank_checker #(
        .KEEP(KEEP)
    ) u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .cmd        (cmd_in),
        .strobe     (strobe),
        .res        (res_out),
        .mismatches (mismatches),
        .outstanding(outstanding)
    );

    // run limit
    always @(posedge clk)
    begin
        cycles++;
        if (cycles > MAX_CYCLE)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // bursts of back-to-back commands with random gaps between them
    task automatic pace();
        int gap;
        begin
            if (burst_left > 0)
                burst_left--;
            if (burst_left == 0)
            begin
                gap = $urandom_range(1, 6);
                start <= 1'b0;
                repeat (gap) @(posedge clk);
                burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 40)
                                                         : $urandom_range(1, 10);
            end
        end
    endtask

    // one command transfer, held until busy is low at an edge
    task automatic put_cmd(input logic op, input logic [31:0] id, input logic [31:0] sc);
        tksel_pkg::cmd_t c;
        begin
            c.opcode = op;
            c.doc_id = id;
            c.score  = sc;
            start  <= 1'b1;
            cmd_in <= c;
            @(posedge clk);
            while (busy)
                @(posedge clk);
            sent++;
            pace();
        end
    endtask

    // score flavours: dense ties, full range, or near the extremes
    function automatic logic [31:0] pick_score(input int mode);
        logic [31:0] sc;
        begin
            case (mode)
                0: sc = $urandom_range(0, 3) << 16;
                1: sc = $urandom;
                default:
                    case ($urandom_range(0, 3))
                        0: sc = 32'h0000_0000;
                        1: sc = 32'hFFFF_FFFF;
                        2: sc = 32'hFFFF_FFFE;
                        default: sc = 32'hFFFF_0000 | $urandom_range(0, 3);
                    endcase
            endcase
            return sc;
        end
    endfunction

    initial
    begin
        int n;
        int mode;
        start  = 1'b0;
        cmd_in = '0;
        rst_n  = 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // drain of an empty store
        put_cmd(tksel_pkg::OP_DRAIN, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        // field extremes and a tie at the top score
        put_cmd(tksel_pkg::OP_OFFER, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        put_cmd(tksel_pkg::OP_OFFER, 32'h0000_0000, 32'h0000_0000);
        put_cmd(tksel_pkg::OP_OFFER, 32'h0000_0001, 32'hFFFF_FFFF);
        put_cmd(tksel_pkg::OP_DRAIN, 32'h0000_0000, 32'h0000_0000);

        // fill the store with four entries sharing the lowest score
        for (int i = 0; i < KEEP; i++)
            put_cmd(tksel_pkg::OP_OFFER, 32'h100 + i,
                    (i < 4) ? 32'h0001_0000 : (i * 32'h0013_0000 + 32'h8000));
        // equal to the lowest when full: dropped
        put_cmd(tksel_pkg::OP_OFFER, 32'hAAAA_AAAA, 32'h0001_0000);
        // just above: replaces the latest of the tied lowest entries
        put_cmd(tksel_pkg::OP_OFFER, 32'h5555_5555, 32'h0001_0001);
        // below the lowest: dropped
        put_cmd(tksel_pkg::OP_OFFER, 32'h1234_5678, 32'h0000_0000);
        put_cmd(tksel_pkg::OP_DRAIN, 32'h0, 32'h0);

        // random offer runs closed by a drain, with stray drains as noise
        while (sent < ITEMS)
        begin
            n    = ($urandom_range(0, 9) == 0) ? $urandom_range(17, 40)
                                               : $urandom_range(0, 20);
            mode = $urandom_range(0, 2);
            for (int k = 0; k < n && sent < ITEMS; k++)
            begin
                if ($urandom_range(0, 19) == 0)
                    put_cmd(tksel_pkg::OP_DRAIN, $urandom, $urandom);
                else
                    put_cmd(tksel_pkg::OP_OFFER, $urandom, pick_score(mode));
            end
            put_cmd(tksel_pkg::OP_DRAIN, $urandom, $urandom);
        end

        // let every due result arrive, then a short settling tail
        start <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (TAIL) @(posedge clk);
        @(negedge clk);
        if (mismatches == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

FILE: files.f
sv/tksel_pkg.sv
sv/tksel_cell.sv
sv/top_k_score_selector_core.sv
sim/tksel_rank_checker.sv
sim/tb_top_k_score_selector_core.sv
